### rtl/core/in_order_commit_reorder_buffer_assert.svh
// Assertion macros for the in-order commit reorder buffer.
// Expects i_clk and i_rst_n in the scope of every use.
`ifndef IN_ORDER_COMMIT_REORDER_BUFFER_ASSERT_SVH
`define IN_ORDER_COMMIT_REORDER_BUFFER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define IOCRB_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("reorder buffer check failed");

// Next-cycle implication, disabled during reset.
`define IOCRB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("reorder buffer check failed");

`endif

### rtl/core/iocrb_pkg.sv
// Shared types, constants and helper functions for the reorder buffer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package iocrb_pkg;

    localparam int WINDOW_DEPTH = 32;
    localparam int MAX_SLOTS    = 8;
    localparam int RESULT_CAP   = 32;

    localparam int VIEW_W = 24;
    localparam int SLOT_W = 3;
    localparam int CNT_W  = 8;
    localparam int SEQ_W  = 48;
    localparam int CFG_W  = 4;
    localparam int IDX_W  = $clog2(WINDOW_DEPTH);
    localparam int RUN_W  = $clog2(RESULT_CAP + 1);

    localparam logic [CFG_W-1:0]  CFG_RESET  = CFG_W'(5);
    localparam logic [VIEW_W-1:0] VIEW_RESET = VIEW_W'(1);
    localparam logic [SEQ_W-1:0]  SEQ_RESET  = SEQ_W'(1);

    localparam logic STATUS_RELEASED = 1'b0;
    localparam logic STATUS_REJECTED = 1'b1;

    typedef struct packed {
        logic [VIEW_W-1:0] batch_view;
        logic [SLOT_W-1:0] batch_slot;
        logic [CNT_W-1:0]  batch_txn_count;
    } t_in_item;

    typedef struct packed {
        logic              status;
        logic [VIEW_W-1:0] out_view;
        logic [SLOT_W-1:0] out_slot;
        logic [SEQ_W-1:0]  first_seq;
        logic [CNT_W-1:0]  out_txn_count;
        logic              last_of_run;
    } t_out_item;

    typedef struct packed {
        logic             ok;
        logic [IDX_W-1:0] idx;
    } t_place;

    typedef struct packed {
        logic             wr_en;
        logic             rd_en;
        logic             clr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [CNT_W-1:0] wr_count;
        logic [IDX_W-1:0] head;
    } t_store_req;

    typedef struct packed {
        logic head_vld;
        logic next_vld;
    } t_store_stat;

    function automatic logic [CFG_W-1:0] eff_slots(input logic [CFG_W-1:0] s);
        logic [CFG_W-1:0] r;
        r = s;
        if (s == '0) begin
            r = CFG_W'(1);
        end else if (s > CFG_W'(MAX_SLOTS)) begin
            r = CFG_W'(MAX_SLOTS);
        end
        return r;
    endfunction

    function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] a);
        logic [IDX_W-1:0] r;
        r = a + IDX_W'(1);
        if (a == IDX_W'(WINDOW_DEPTH - 1)) begin
            r = '0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/iocrb_place.sv
// Window check and ring index for one incoming batch.
// Depends on iocrb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iocrb_place
    import iocrb_pkg::*;
(
    input  wire t_in_item          i_item,
    input  wire [VIEW_W-1:0]       i_next_view,
    input  wire [SLOT_W-1:0]       i_next_slot,
    input  wire [IDX_W-1:0]        i_head,
    input  wire [CFG_W-1:0]        i_slots,
    output t_place                 o_place
);

    localparam int PROD_W = VIEW_W + CFG_W + 1;
    localparam int DIST_W = PROD_W + 1;

    logic [VIEW_W-1:0]        dv;
    logic signed [PROD_W-1:0] prod;
    logic signed [DIST_W-1:0] gap;
    logic                     slot_ok;
    logic                     in_win;
    logic [IDX_W:0]           sum;

    always_comb begin
        dv   = i_item.batch_view - i_next_view;
        prod = PROD_W'($signed(dv)) * PROD_W'($signed({1'b0, i_slots}));
        gap  = DIST_W'(prod)
             + $signed({{(DIST_W - SLOT_W){1'b0}}, i_item.batch_slot})
             - $signed({{(DIST_W - SLOT_W){1'b0}}, i_next_slot});
        slot_ok = CFG_W'(i_item.batch_slot) < i_slots;
        in_win  = !gap[DIST_W-1] && (gap < $signed(DIST_W'(WINDOW_DEPTH)));
        sum     = {1'b0, i_head} + {1'b0, gap[IDX_W-1:0]};
        if (sum >= (IDX_W + 1)'(WINDOW_DEPTH)) begin
            sum = sum - (IDX_W + 1)'(WINDOW_DEPTH);
        end
        o_place.ok  = slot_ok && in_win;
        o_place.idx = sum[IDX_W-1:0];
    end

endmodule

`default_nettype wire

### rtl/core/iocrb_store.sv
// Ring store: count memory with registered read, plus per-entry valid bits.
// Depends on iocrb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iocrb_store
    import iocrb_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire t_store_req    i_req,
    output logic [CNT_W-1:0]   o_rdata,
    output t_store_stat        o_stat
);

    logic [CNT_W-1:0]        r_mem [WINDOW_DEPTH];
    logic [CNT_W-1:0]        r_rdata;
    logic [WINDOW_DEPTH-1:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rdata <= r_mem[i_req.head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (i_req.wr_en) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.clr_en) begin
                r_valid[i_req.head] <= 1'b0;
            end
        end
    end

    assign o_rdata         = r_rdata;
    assign o_stat.head_vld = r_valid[i_req.head];
    assign o_stat.next_vld = r_valid[ring_inc(i_req.head)];

endmodule

`default_nettype wire

### rtl/core/in_order_commit_reorder_buffer.sv
// Top level of the in-order commit reorder buffer: control sequencer and output register.
// Depends on iocrb_pkg, iocrb_place, iocrb_store and the assertion macro header.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one batch per
//   transaction. Output channel (o_out_valid / i_out_stall / o_out_data) carries
//   released batches in key order, and a rejection result for a batch that falls
//   outside the window or uses a slot beyond slots_in_use. last_of_run marks the
//   final result caused by one input; an input that only fills a gap gives none.
//   Configuration: i_cfg_we writes i_cfg_data into slots_in_use; user must write only while idle (unenforced).
// Sequencing:
//   An input is taken only in the idle state; S_PLACE then checks it and, if it fits,
//   writes it into the ring. A release goes on through S_DRAIN and S_EMIT to the output
//   register, a rejection through S_REJ. Each released batch takes a count-memory read
//   (S_DRAIN), then an output load (S_EMIT). o_in_stall stays high until the run ends,
//   receiver stalls included; at most 32 results per input.
// Reset and stall:
//   Synchronous active-low reset clears all valid bits at once, restores view 1,
//   slot 0, sequence 1 and slots_in_use 5. A stalled output holds its result and
//   the sequencer waits; the input side stays stalled until the run is finished.
`timescale 1ns / 1ps
`default_nettype none

`include "in_order_commit_reorder_buffer_assert.svh"

module in_order_commit_reorder_buffer
    import iocrb_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_stall,
    input  wire t_in_item     i_in_data,
    output logic              o_out_valid,
    input  wire               i_out_stall,
    output t_out_item         o_out_data,
    input  wire               i_cfg_we,
    input  wire [CFG_W-1:0]   i_cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PLACE = 5'b00010,
        S_REJ   = 5'b00100,
        S_DRAIN = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    t_in_item          r_in;
    logic [CFG_W-1:0]  r_cfg;
    logic [VIEW_W-1:0] r_next_view, n_next_view;
    logic [SLOT_W-1:0] r_next_slot, n_next_slot;
    logic [SEQ_W-1:0]  r_next_seq, n_next_seq;
    logic [IDX_W-1:0]  r_head, n_head;
    logic [RUN_W-1:0]  r_run, n_run;
    logic              r_out_valid;
    t_out_item         r_out, n_out;

    logic              in_accept;
    logic              out_free;
    logic              out_load;
    logic [CFG_W-1:0]  slots;
    logic [CFG_W-1:0]  slot_inc;
    logic              last;
    t_place            place;
    t_store_req        req;
    t_store_stat       stat;
    logic [CNT_W-1:0]  rdata;

    assign slots     = eff_slots(r_cfg);
    assign in_accept = i_in_valid && (r_state == S_IDLE);
    assign out_free  = !r_out_valid || !i_out_stall;

    iocrb_place u_place (
        .i_item      (r_in),
        .i_next_view (r_next_view),
        .i_next_slot (r_next_slot),
        .i_head      (r_head),
        .i_slots     (slots),
        .o_place     (place)
    );

    iocrb_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rdata (rdata),
        .o_stat  (stat)
    );

    always_comb begin
        n_state     = r_state;
        n_next_view = r_next_view;
        n_next_slot = r_next_slot;
        n_next_seq  = r_next_seq;
        n_head      = r_head;
        n_run       = r_run;
        n_out       = r_out;
        out_load    = 1'b0;
        last        = 1'b0;
        slot_inc    = CFG_W'(r_next_slot) + CFG_W'(1);
        req         = '0;
        req.head     = r_head;
        req.wr_addr  = place.idx;
        req.wr_count = r_in.batch_txn_count;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_run   = '0;
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                if (place.ok) begin
                    req.wr_en = 1'b1;
                    n_state   = S_DRAIN;
                end else begin
                    n_state = S_REJ;
                end
            end
            S_REJ: begin
                if (out_free) begin
                    out_load            = 1'b1;
                    n_out.status        = STATUS_REJECTED;
                    n_out.out_view      = r_in.batch_view;
                    n_out.out_slot      = r_in.batch_slot;
                    n_out.first_seq     = '0;
                    n_out.out_txn_count = '0;
                    n_out.last_of_run   = !stat.head_vld;
                    n_run               = RUN_W'(1);
                    n_state             = stat.head_vld ? S_DRAIN : S_IDLE;
                end
            end
            S_DRAIN: begin
                if (stat.head_vld) begin
                    req.rd_en = 1'b1;
                    n_state   = S_EMIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    last                = (r_run == RUN_W'(RESULT_CAP - 1)) || !stat.next_vld;
                    out_load            = 1'b1;
                    req.clr_en          = 1'b1;
                    n_out.status        = STATUS_RELEASED;
                    n_out.out_view      = r_next_view;
                    n_out.out_slot      = r_next_slot;
                    n_out.first_seq     = r_next_seq;
                    n_out.out_txn_count = rdata;
                    n_out.last_of_run   = last;
                    n_next_seq          = r_next_seq + SEQ_W'(rdata);
                    n_head              = ring_inc(r_head);
                    n_run               = r_run + RUN_W'(1);
                    if (slot_inc >= slots) begin
                        n_next_slot = '0;
                        n_next_view = r_next_view + VIEW_W'(1);
                    end else begin
                        n_next_slot = slot_inc[SLOT_W-1:0];
                    end
                    n_state = last ? S_IDLE : S_DRAIN;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg       <= CFG_RESET;
            r_next_view <= VIEW_RESET;
            r_next_slot <= '0;
            r_next_seq  <= SEQ_RESET;
            r_head      <= '0;
            r_run       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_next_view <= n_next_view;
            r_next_slot <= n_next_slot;
            r_next_seq  <= n_next_seq;
            r_head      <= n_head;
            r_run       <= n_run;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_data;
        end
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `IOCRB_ASSERT_IMPL(a_rw_excl, req.rd_en, !req.wr_en && !req.clr_en)
    `IOCRB_ASSERT_IMPL(a_emit_head_vld, r_state == S_EMIT, stat.head_vld)
    `IOCRB_ASSERT_IMPL(a_run_cap, r_state == S_EMIT, r_run < RUN_W'(RESULT_CAP))
    `IOCRB_ASSERT_NEXT(a_load_shows, out_load, r_out_valid && (r_out == $past(n_out)))

endmodule

`default_nettype wire

### tb/in_order_commit_reorder_buffer_tb.sv
`timescale 1ns / 1ps
// Testbench for in_order_commit_reorder_buffer: directed and random batches, scoreboard check.
// Depends on iocrb_pkg and the block's RTL; holds its own model of the release order.

module in_order_commit_reorder_buffer_tb;
    import iocrb_pkg::*;

    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          SETTLE_CYCLES = 16;
    localparam int          DRAIN_CYCLES  = 100;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          PHASE_ITEMS   = 30;
    localparam int          NUM_PHASES    = 8;
    localparam int          REPORT_LIMIT  = 10;
    localparam logic [3:0]  PHASE_SLOTS [NUM_PHASES] = '{4'd1, 4'd8, 4'd0, 4'd15,
                                                         4'd3, 4'd9, 4'd2, 4'd5};

    class release_tracker;
        logic [CFG_W-1:0]  slots_cfg;
        logic [VIEW_W-1:0] next_view;
        int                next_slot;
        logic [SEQ_W-1:0]  next_seq;
        int                ring_head;
        bit                entry_valid [WINDOW_DEPTH];
        logic [CNT_W-1:0]  entry_count [WINDOW_DEPTH];
        t_out_item         expected_releases [$];
        int                errors;

        function new();
            slots_cfg = CFG_RESET;
            next_view = VIEW_RESET;
            next_slot = 0;
            next_seq  = SEQ_RESET;
            ring_head = 0;
            errors    = 0;
            foreach (entry_valid[i]) entry_valid[i] = 1'b0;
        endfunction

        function void set_slots(logic [CFG_W-1:0] v);
            slots_cfg = v;
        endfunction

        function int slot_limit();
            if (slots_cfg == 0) return 1;
            if (slots_cfg > MAX_SLOTS) return MAX_SLOTS;
            return int'(slots_cfg);
        endfunction

        function int pending();
            return expected_releases.size();
        endfunction

        // Key at distance d from the next key to be released.
        function t_in_item key_from_next(int d, logic [CNT_W-1:0] cnt);
            int       s;
            int       pos;
            int       vo;
            t_in_item k;
            s   = slot_limit();
            pos = next_slot + d;
            if (pos >= 0) vo = pos / s;
            else vo = -((s - 1 - pos) / s);
            k.batch_view      = next_view + VIEW_W'(vo);
            k.batch_slot      = SLOT_W'(pos - vo * s);
            k.batch_txn_count = cnt;
            return k;
        endfunction

        function void note_batch(t_in_item it);
            int                s;
            int                vd;
            int                d;
            int                idx;
            logic [VIEW_W-1:0] dv;
            bit                rejected;
            t_out_item         r;
            t_out_item         run [$];
            s        = slot_limit();
            rejected = 1'b1;
            if (int'(it.batch_slot) < s) begin
                dv = it.batch_view - next_view;
                vd = dv[VIEW_W-1] ? int'(dv) - (1 << VIEW_W) : int'(dv);
                d  = vd * s + int'(it.batch_slot) - next_slot;
                if (d >= 0 && d < WINDOW_DEPTH) begin
                    idx              = (ring_head + d) % WINDOW_DEPTH;
                    entry_valid[idx] = 1'b1;
                    entry_count[idx] = it.batch_txn_count;
                    rejected         = 1'b0;
                end
            end
            if (rejected) begin
                r.status        = STATUS_REJECTED;
                r.out_view      = it.batch_view;
                r.out_slot      = it.batch_slot;
                r.first_seq     = '0;
                r.out_txn_count = '0;
                r.last_of_run   = 1'b0;
                run.insert(run.size(), r);
            end
            while (run.size() < RESULT_CAP && entry_valid[ring_head]) begin
                r.status        = STATUS_RELEASED;
                r.out_view      = next_view;
                r.out_slot      = SLOT_W'(next_slot);
                r.first_seq     = next_seq;
                r.out_txn_count = entry_count[ring_head];
                r.last_of_run   = 1'b0;
                run.insert(run.size(), r);
                next_seq               = next_seq + SEQ_W'(entry_count[ring_head]);
                entry_valid[ring_head] = 1'b0;
                ring_head              = (ring_head + 1) % WINDOW_DEPTH;
                next_slot++;
                if (next_slot >= s) begin
                    next_slot = 0;
                    next_view = next_view + VIEW_W'(1);
                end
            end
            if (run.size() > 0) begin
                r             = run.pop_back();
                r.last_of_run = 1'b1;
                run.insert(run.size(), r);
            end
            foreach (run[i]) expected_releases.insert(expected_releases.size(), run[i]);
        endfunction

        function void check_release(t_out_item got);
            t_out_item exp;
            if (expected_releases.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("unexpected result: st=%0d view=%0h slot=%0d seq=%0h cnt=%0d last=%0d",
                             got.status, got.out_view, got.out_slot, got.first_seq,
                             got.out_txn_count, got.last_of_run);
                return;
            end
            exp = expected_releases.pop_front();
            if (got.status !== exp.status || got.out_view !== exp.out_view ||
                got.out_slot !== exp.out_slot || got.first_seq !== exp.first_seq ||
                got.out_txn_count !== exp.out_txn_count ||
                got.last_of_run !== exp.last_of_run) begin
                errors++;
                if (errors <= REPORT_LIMIT) begin
                    $display("mismatch exp: st=%0d view=%0h slot=%0d seq=%0h cnt=%0d last=%0d",
                             exp.status, exp.out_view, exp.out_slot, exp.first_seq,
                             exp.out_txn_count, exp.last_of_run);
                    $display("         got: st=%0d view=%0h slot=%0d seq=%0h cnt=%0d last=%0d",
                             got.status, got.out_view, got.out_slot, got.first_seq,
                             got.out_txn_count, got.last_of_run);
                end
            end
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    t_in_item         in_data;
    logic             out_valid;
    logic             out_stall;
    t_out_item        out_data;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_data;

    release_tracker   tracker;
    int               items_sent;
    int               cycle_count;
    bit               quiet;
    bit               hold_off_req;

    always #6 clk = ~clk;

    in_order_commit_reorder_buffer u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) tracker.check_release(out_data);
    end

    // Output stall bursts; one long hold-off on request.
    initial begin
        int level;
        int len;
        @(posedge rst_n);
        forever begin
            if (hold_off_req) begin
                repeat (HOLD_CYCLES) @(negedge clk) out_stall <= 1'b1;
                hold_off_req = 1'b0;
            end else begin
                if (quiet) begin
                    level = 0;
                    len   = 1;
                end else begin
                    level = ($urandom_range(0, 2) == 0);
                    len   = level ? $urandom_range(1, 14) : $urandom_range(1, 60);
                end
                repeat (len) @(negedge clk) out_stall <= level[0];
            end
        end
    end

    task automatic pause_input(input int n);
        repeat (n) @(negedge clk) in_valid <= 1'b0;
    endtask

    task automatic offer(input t_in_item it);
        if (!quiet && $urandom_range(0, 3) == 0) pause_input($urandom_range(1, 14));
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        tracker.note_batch(it);
        items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk) in_valid <= 1'b0;
        while (tracker.pending() > 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_slots(input logic [CFG_W-1:0] v);
        wait_drained();
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        tracker.set_slots(v);
        @(negedge clk) cfg_we <= 1'b0;
    endtask

    function automatic t_in_item noise_item();
        t_in_item it;
        int       s;
        s = tracker.slot_limit();
        case ($urandom_range(0, 3))
            0: it = tracker.key_from_next($urandom_range(WINDOW_DEPTH, WINDOW_DEPTH + 16),
                                          CNT_W'($urandom_range(0, 255)));
            1: it = tracker.key_from_next(-$urandom_range(1, 48),
                                          CNT_W'($urandom_range(0, 255)));
            2: begin
                it = tracker.key_from_next(0, CNT_W'($urandom_range(0, 255)));
                if (s < MAX_SLOTS) it.batch_slot = SLOT_W'($urandom_range(s, MAX_SLOTS - 1));
            end
            default: begin
                it.batch_view      = VIEW_W'($urandom);
                it.batch_slot      = SLOT_W'($urandom);
                it.batch_txn_count = CNT_W'($urandom);
            end
        endcase
        return it;
    endfunction

    task automatic run_random(input int n);
        int       target;
        int       k;
        int       i;
        int       j;
        t_in_item tmp;
        t_in_item keys [$];
        target = items_sent + n;
        while (items_sent < target) begin
            if ($urandom_range(0, 99) < 75) begin
                k = ($urandom_range(0, 9) == 0) ? WINDOW_DEPTH : $urandom_range(1, 12);
                keys.delete();
                for (i = 0; i < k; i++)
                    keys.insert(keys.size(),
                                tracker.key_from_next(i, CNT_W'($urandom_range(0, 255))));
                for (i = k - 1; i > 0; i--) begin
                    j       = $urandom_range(0, i);
                    tmp     = keys[i];
                    keys[i] = keys[j];
                    keys[j] = tmp;
                end
                if (k > 1 && $urandom_range(0, 6) == 0) keys.delete($urandom_range(0, k - 1));
                if ($urandom_range(0, 9) == 0) begin
                    tmp = keys[$urandom_range(0, keys.size() - 1)];
                    tmp.batch_txn_count = CNT_W'($urandom_range(0, 255));
                    keys.insert($urandom_range(0, keys.size()), tmp);
                end
                for (i = 0; i < keys.size(); i++) begin
                    if ($urandom_range(0, 9) == 0) offer(noise_item());
                    offer(keys[i]);
                end
            end else begin
                offer(noise_item());
            end
        end
    endtask

    task automatic run_directed();
        t_in_item a;
        t_in_item b;
        a = tracker.key_from_next(0, 8'hFF);
        offer(a);
        a = tracker.key_from_next(1, 8'd10);
        b = tracker.key_from_next(1, 8'd20);
        offer(a);
        offer(b);
        offer(tracker.key_from_next(0, 8'd0));
        a = tracker.key_from_next(0, 8'd1);
        a.batch_slot = 3'd7;
        offer(a);
        offer(tracker.key_from_next(-1, 8'd5));
        offer('{batch_view: 24'hFFFFFF, batch_slot: 3'd0, batch_txn_count: 8'd1});
        offer('{batch_view: 24'h000000, batch_slot: 3'd4, batch_txn_count: 8'd1});
        a = tracker.key_from_next(0, 8'd2);
        a.batch_view = a.batch_view + 24'h800000;
        offer(a);
        a = tracker.key_from_next(0, 8'd2);
        a.batch_view = a.batch_view + 24'h7FFFFF;
        offer(a);
        offer(tracker.key_from_next(WINDOW_DEPTH - 1, 8'hAA));
        offer(tracker.key_from_next(WINDOW_DEPTH, 8'h01));
        offer(tracker.key_from_next(0, 8'h55));
        offer(tracker.key_from_next(3, 8'h80));
        offer(tracker.key_from_next(2, 8'h7F));
        offer(tracker.key_from_next(1, 8'h01));
        offer(tracker.key_from_next(0, 8'hFE));
    endtask

    initial begin
        int p;
        tracker      = new();
        items_sent   = 0;
        cycle_count  = 0;
        quiet        = 1'b0;
        hold_off_req = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        out_stall    = 1'b0;
        cfg_we       = 1'b0;
        cfg_data     = '0;
        repeat (2) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        write_slots(CFG_RESET);
        run_directed();
        for (p = 0; p < NUM_PHASES; p++) begin
            write_slots(PHASE_SLOTS[p]);
            if (p == 1) hold_off_req = 1'b1;
            if (p == NUM_PHASES - 1) quiet = 1'b1;
            run_random(PHASE_ITEMS);
        end

        @(negedge clk) in_valid <= 1'b0;
        while (tracker.pending() > 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        tracker.errors += tracker.pending();
        if (tracker.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/iocrb_pkg.sv
rtl/core/iocrb_place.sv
rtl/core/iocrb_store.sv
rtl/core/in_order_commit_reorder_buffer.sv
tb/in_order_commit_reorder_buffer_tb.sv
